### src/look_at_view_matrix_macros.svh
// Assertion macros shared by the look-at view matrix modules.
`ifndef LOOK_AT_VIEW_MATRIX_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LAVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("look-at view matrix assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LAVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("look-at view matrix assertion failed");

`endif

### src/lavm_pkg.sv
// Types, widths and constants shared by the look-at view matrix modules.
package lavm_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 32;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int MAG_W       = DIFF_W;
  localparam int NV_W        = FRAC_BITS + 2;
  localparam int NORM_MSB    = 29;
  localparam int SQ_OP_W     = NORM_MSB + 1;
  localparam int SQ_W        = 2 * SQ_OP_W + 2;
  localparam int ROOT_W      = SQ_W + 1;
  localparam int N_W         = SQ_OP_W + 2;
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int STEP_W      = $clog2(QUO_W);
  localparam int PROD_W      = NV_W + COORD_W;
  localparam int TR_W        = PROD_W - FRAC_BITS;
  localparam int ACC_W       = TR_W + 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [NV_W-1:0]    nv_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t FX_ONE    = COORD_W'(1) << FRAC_BITS;
  localparam logic [1:0] LAST_COL = 2'd3;

  typedef struct packed {
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    coord_t target_x;
    coord_t target_y;
    coord_t target_z;
  } in_word_t;

  typedef struct packed {
    logic [1:0] column_index;
    coord_t     row0_value;
    coord_t     row1_value;
    coord_t     row2_value;
    coord_t     row3_value;
    logic       last_column;
    logic       degenerate;
  } out_word_t;

  typedef struct packed {
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    diff_t  d_x;
    diff_t  d_y;
    diff_t  d_z;
    logic   same_point;
  } job_t;

  typedef struct packed {
    logic done;
    logic ok;
  } norm_stat_t;

endpackage

### src/lavm_queue.sv
// Two-entry job queue between the front and back parts.
`include "look_at_view_matrix_macros.svh"

module lavm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lavm_pkg::job_t push_data,
  input  logic          pop,
  output lavm_pkg::job_t pop_data,
  output logic          full,
  output logic          empty
);

  lavm_pkg::job_t mem_r [lavm_pkg::QUEUE_DEPTH];
  logic [lavm_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [lavm_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [lavm_pkg::QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == lavm_pkg::QCNT_W'(lavm_pkg::QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `LAVM_ASSERT_IMP(a_push_not_full, clk, rst_n, push, !full)
  `LAVM_ASSERT_IMP(a_pop_not_empty, clk, rst_n, pop, !empty)
  `LAVM_ASSERT_NXT(a_push_fills, clk, rst_n, push && !pop, !empty)

endmodule

### src/lavm_front.sv
// Front part: takes input words, forms the eye-to-target difference and flags coincident points.
module lavm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  lavm_pkg::in_word_t in_word,
  output logic               busy,
  output logic               push,
  output lavm_pkg::job_t     push_data,
  input  logic               full
);

  lavm_pkg::job_t stage_r;
  lavm_pkg::job_t job;
  logic           stage_vld_r;
  logic           accept;

  assign busy      = stage_vld_r && full;
  assign push      = stage_vld_r && !full;
  assign push_data = stage_r;
  assign accept    = start && !busy;

  always_comb begin
    job.eye_x = in_word.eye_x;
    job.eye_y = in_word.eye_y;
    job.eye_z = in_word.eye_z;
    job.d_x = lavm_pkg::DIFF_W'($signed(in_word.target_x))
            - lavm_pkg::DIFF_W'($signed(in_word.eye_x));
    job.d_y = lavm_pkg::DIFF_W'($signed(in_word.target_y))
            - lavm_pkg::DIFF_W'($signed(in_word.eye_y));
    job.d_z = lavm_pkg::DIFF_W'($signed(in_word.target_z))
            - lavm_pkg::DIFF_W'($signed(in_word.eye_z));
    job.same_point = (in_word.eye_x == in_word.target_x)
                  && (in_word.eye_y == in_word.target_y)
                  && (in_word.eye_z == in_word.target_z);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else if (accept) begin
      stage_vld_r <= 1'b1;
    end else if (push) begin
      stage_vld_r <= 1'b0;
    end
  end

endmodule

### src/lavm_norm.sv
// Iterative vector normalisation unit: range shift, sum of squares, square root and division.
module lavm_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  lavm_pkg::diff_t      vin [3],
  output lavm_pkg::norm_stat_t stat,
  output lavm_pkg::nv_t        vout [3]
);

  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV} nstate_t;

  localparam int PSQ_W = 2 * lavm_pkg::SQ_OP_W;

  nstate_t                          state_r;
  logic [lavm_pkg::MAG_W-1:0]       mag_r [3];
  logic [2:0]                       neg_r;
  logic [1:0]                       idx_r;
  logic [PSQ_W-1:0]                 prod_r;
  logic [lavm_pkg::SQ_W-1:0]        sum_r;
  logic [lavm_pkg::ROOT_W-1:0]      x_r;
  logic [lavm_pkg::ROOT_W-1:0]      res_r;
  logic [lavm_pkg::ROOT_W-1:0]      bit_r;
  logic [lavm_pkg::N_W-1:0]         rem_r;
  logic [lavm_pkg::QUO_W-1:0]       quo_r;
  logic [lavm_pkg::STEP_W-1:0]      step_r;
  logic [1:0]                       comp_r;
  lavm_pkg::nv_t                    vout_r [3];
  logic                             done_r;
  logic                             ok_r;

  logic                             any_big;
  logic                             all_small;
  logic                             all_zero;
  logic [lavm_pkg::SQ_OP_W-1:0]     sq_op;
  logic [PSQ_W-1:0]                 sq_prod;
  logic [lavm_pkg::ROOT_W-1:0]      trial;
  logic                             sq_ge;
  logic [lavm_pkg::MAG_W-1:0]       mag_cur;
  logic [lavm_pkg::MAG_W-1:0]       mag_next;
  logic                             cur_neg;
  logic [lavm_pkg::N_W:0]           div_t;
  logic                             div_ge;
  logic [lavm_pkg::QUO_W-1:0]       quo_full;
  lavm_pkg::nv_t                    q_ext;
  lavm_pkg::nv_t                    q_signed;

  assign stat.done = done_r;
  assign stat.ok   = ok_r;
  assign vout      = vout_r;

  always_comb begin
    any_big   = 1'b0;
    all_small = 1'b1;
    all_zero  = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (|mag_r[i][lavm_pkg::MAG_W-1:lavm_pkg::NORM_MSB+1]) begin
        any_big = 1'b1;
      end
      if (|mag_r[i][lavm_pkg::MAG_W-1:lavm_pkg::NORM_MSB]) begin
        all_small = 1'b0;
      end
      if (vin[i] != '0) begin
        all_zero = 1'b0;
      end
    end
    case (idx_r)
      2'd0:    sq_op = mag_r[0][lavm_pkg::SQ_OP_W-1:0];
      2'd1:    sq_op = mag_r[1][lavm_pkg::SQ_OP_W-1:0];
      default: sq_op = mag_r[2][lavm_pkg::SQ_OP_W-1:0];
    endcase
    sq_prod = sq_op * sq_op;
    trial   = res_r + bit_r;
    sq_ge   = (x_r >= trial);
    case (comp_r)
      2'd0: begin
        mag_cur  = mag_r[0];
        mag_next = mag_r[1];
        cur_neg  = neg_r[0];
      end
      2'd1: begin
        mag_cur  = mag_r[1];
        mag_next = mag_r[2];
        cur_neg  = neg_r[1];
      end
      default: begin
        mag_cur  = mag_r[2];
        mag_next = mag_r[2];
        cur_neg  = neg_r[2];
      end
    endcase
    div_t = {rem_r, (step_r == lavm_pkg::STEP_W'(lavm_pkg::FRAC_BITS)) ? mag_cur[0] : 1'b0};
    div_ge   = (div_t >= {1'b0, res_r[lavm_pkg::N_W-1:0]});
    quo_full = {quo_r[lavm_pkg::QUO_W-2:0], div_ge};
    q_ext    = lavm_pkg::nv_t'({1'b0, quo_full});
    q_signed = cur_neg ? -q_ext : q_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i]  <= vin[i][lavm_pkg::DIFF_W-1] ? lavm_pkg::MAG_W'(-vin[i])
                                                       : lavm_pkg::MAG_W'(vin[i]);
              neg_r[i]  <= vin[i][lavm_pkg::DIFF_W-1];
              vout_r[i] <= '0;
            end
            if (all_zero) begin
              ok_r   <= 1'b0;
              done_r <= 1'b1;
            end else begin
              state_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (any_big) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i] <= mag_r[i] >> 1;
            end
          end else if (all_small) begin
            for (int i = 0; i < 3; i++) begin
              mag_r[i] <= mag_r[i] << 1;
            end
          end else begin
            idx_r   <= 2'd0;
            sum_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          if (idx_r != 2'd3) begin
            prod_r <= sq_prod;
          end
          if (idx_r != 2'd0) begin
            sum_r <= sum_r + lavm_pkg::SQ_W'(prod_r);
          end
          if (idx_r == 2'd3) begin
            x_r     <= lavm_pkg::ROOT_W'(sum_r + lavm_pkg::SQ_W'(prod_r));
            res_r   <= '0;
            bit_r   <= lavm_pkg::ROOT_W'(1) << (lavm_pkg::SQ_W - 2);
            state_r <= N_SQRT;
          end
          idx_r <= idx_r + 2'd1;
        end
        N_SQRT: begin
          if (sq_ge) begin
            x_r   <= x_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            comp_r  <= 2'd0;
            step_r  <= lavm_pkg::STEP_W'(lavm_pkg::FRAC_BITS);
            rem_r   <= lavm_pkg::N_W'(mag_r[0] >> 1);
            state_r <= N_DIV;
          end
        end
        N_DIV: begin
          rem_r <= div_ge ? lavm_pkg::N_W'(div_t - {1'b0, res_r[lavm_pkg::N_W-1:0]})
                          : lavm_pkg::N_W'(div_t);
          quo_r <= quo_full;
          if (step_r == '0) begin
            for (int i = 0; i < 3; i++) begin
              if (comp_r == 2'(i)) begin
                vout_r[i] <= q_signed;
              end
            end
            if (comp_r == 2'd2) begin
              ok_r    <= 1'b1;
              done_r  <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              comp_r <= comp_r + 2'd1;
              step_r <= lavm_pkg::STEP_W'(lavm_pkg::FRAC_BITS);
              rem_r  <= lavm_pkg::N_W'(mag_next >> 1);
            end
          end else begin
            step_r <= step_r - 1'b1;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

endmodule

### src/lavm_back.sv
// Back part: sequences the three normalisations, the cross and dot products and the column output.
`include "look_at_view_matrix_macros.svh"

module lavm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  lavm_pkg::job_t      q_data,
  output logic                q_pop,
  output logic                out_valid,
  output lavm_pkg::out_word_t out_word
);

  typedef enum logic [2:0] {B_IDLE, B_NF, B_NR, B_CROSS, B_NU, B_DOT, B_EMIT} bstate_t;

  localparam int CROSS_N = 4;
  localparam int DOT_N   = 9;
  localparam int BSTEP_W = $clog2(DOT_N + 2);

  bstate_t                           state_r;
  lavm_pkg::job_t                    job_r;
  lavm_pkg::nv_t                     f_r [3];
  lavm_pkg::nv_t                     r_r [3];
  lavm_pkg::nv_t                     u_r [3];
  lavm_pkg::acc_t                    acc_r [3];
  logic                              degen_r;
  logic [BSTEP_W-1:0]                step_r;
  logic signed [lavm_pkg::PROD_W-1:0] prod_r;
  logic [1:0]                        ptgt_r;
  logic                              pneg_r;
  logic                              pv_r;
  logic [1:0]                        col_r;
  logic                              nstart_r;
  lavm_pkg::diff_t                   nvec_r [3];
  logic                              out_valid_r;
  lavm_pkg::out_word_t               out_word_r;

  lavm_pkg::norm_stat_t              nstat;
  lavm_pkg::nv_t                     nvout [3];
  lavm_pkg::nv_t                     op_a;
  lavm_pkg::coord_t                  op_b;
  logic [1:0]                        op_tgt;
  logic                              op_neg;
  logic                              issue;
  lavm_pkg::nv_t                     vsel [3];
  lavm_pkg::coord_t                  eye [3];
  logic [1:0]                        opk;
  lavm_pkg::acc_t                    padd;
  lavm_pkg::out_word_t               col_word;

  function automatic logic signed [lavm_pkg::TR_W-1:0] trunc_fx(
    input logic signed [lavm_pkg::PROD_W-1:0] p
  );
    logic [lavm_pkg::PROD_W-1:0] mag;
    logic [lavm_pkg::PROD_W-1:0] sh;
    mag = p[lavm_pkg::PROD_W-1] ? lavm_pkg::PROD_W'(-p) : lavm_pkg::PROD_W'(p);
    sh  = mag >> lavm_pkg::FRAC_BITS;
    return p[lavm_pkg::PROD_W-1] ? -$signed(sh[lavm_pkg::TR_W-1:0])
                                 : $signed(sh[lavm_pkg::TR_W-1:0]);
  endfunction

  function automatic lavm_pkg::coord_t sat_fx(input logic signed [lavm_pkg::ACC_W:0] x);
    logic signed [lavm_pkg::ACC_W:0] hi;
    logic signed [lavm_pkg::ACC_W:0] lo;
    hi = (lavm_pkg::ACC_W + 1)'(lavm_pkg::COORD_MAX);
    lo = (lavm_pkg::ACC_W + 1)'(lavm_pkg::COORD_MIN);
    if (x > hi) begin
      return lavm_pkg::COORD_MAX;
    end
    if (x < lo) begin
      return lavm_pkg::COORD_MIN;
    end
    return x[lavm_pkg::COORD_W-1:0];
  endfunction

  lavm_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nstart_r),
    .vin   (nvec_r),
    .stat  (nstat),
    .vout  (nvout)
  );

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    eye[0] = job_r.eye_x;
    eye[1] = job_r.eye_y;
    eye[2] = job_r.eye_z;
    op_a   = r_r[0];
    op_b   = '0;
    op_tgt = 2'd0;
    op_neg = 1'b0;
    vsel   = r_r;
    opk    = 2'd0;
    issue  = 1'b0;
    if (state_r == B_CROSS) begin
      issue = (step_r < BSTEP_W'(CROSS_N));
      case (step_r)
        BSTEP_W'(0): begin
          op_a = r_r[1]; op_b = lavm_pkg::COORD_W'(f_r[2]); op_tgt = 2'd0; op_neg = 1'b0;
        end
        BSTEP_W'(1): begin
          op_a = r_r[0]; op_b = lavm_pkg::COORD_W'(f_r[2]); op_tgt = 2'd1; op_neg = 1'b1;
        end
        BSTEP_W'(2): begin
          op_a = r_r[0]; op_b = lavm_pkg::COORD_W'(f_r[1]); op_tgt = 2'd2; op_neg = 1'b0;
        end
        default: begin
          op_a = r_r[1]; op_b = lavm_pkg::COORD_W'(f_r[0]); op_tgt = 2'd2; op_neg = 1'b1;
        end
      endcase
    end else if (state_r == B_DOT) begin
      issue = (step_r < BSTEP_W'(DOT_N));
      case (step_r)
        BSTEP_W'(0), BSTEP_W'(1), BSTEP_W'(2): begin
          vsel = r_r; op_tgt = 2'd0;
        end
        BSTEP_W'(3), BSTEP_W'(4), BSTEP_W'(5): begin
          vsel = u_r; op_tgt = 2'd1;
        end
        default: begin
          vsel = f_r; op_tgt = 2'd2;
        end
      endcase
      case (step_r)
        BSTEP_W'(0), BSTEP_W'(3), BSTEP_W'(6): opk = 2'd0;
        BSTEP_W'(1), BSTEP_W'(4), BSTEP_W'(7): opk = 2'd1;
        default:                               opk = 2'd2;
      endcase
      case (opk)
        2'd0:    begin op_a = vsel[0]; op_b = eye[0]; end
        2'd1:    begin op_a = vsel[1]; op_b = eye[1]; end
        default: begin op_a = vsel[2]; op_b = eye[2]; end
      endcase
    end
    padd = lavm_pkg::ACC_W'(trunc_fx(prod_r));
    if (pneg_r) begin
      padd = -padd;
    end
  end

  always_comb begin
    col_word.column_index = col_r;
    col_word.last_column  = (col_r == lavm_pkg::LAST_COL);
    col_word.degenerate   = degen_r;
    col_word.row0_value   = '0;
    col_word.row1_value   = '0;
    col_word.row2_value   = '0;
    col_word.row3_value   = '0;
    if (!degen_r) begin
      case (col_r)
        2'd0, 2'd1, 2'd2: begin
          col_word.row0_value = lavm_pkg::COORD_W'(r_r[col_r]);
          col_word.row1_value = lavm_pkg::COORD_W'(u_r[col_r]);
          col_word.row2_value = lavm_pkg::COORD_W'(-f_r[col_r]);
        end
        default: begin
          col_word.row0_value = sat_fx(-((lavm_pkg::ACC_W + 1)'(acc_r[0])));
          col_word.row1_value = sat_fx(-((lavm_pkg::ACC_W + 1)'(acc_r[1])));
          col_word.row2_value = sat_fx((lavm_pkg::ACC_W + 1)'(acc_r[2]));
          col_word.row3_value = lavm_pkg::FX_ONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      nstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pv_r        <= 1'b0;
    end else begin
      nstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pv_r        <= issue;
      if (issue) begin
        prod_r <= op_a * op_b;
        ptgt_r <= op_tgt;
        pneg_r <= op_neg;
      end
      if (pv_r) begin
        for (int i = 0; i < 3; i++) begin
          if (ptgt_r == 2'(i)) begin
            acc_r[i] <= acc_r[i] + padd;
          end
        end
      end
      case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            job_r <= q_data;
            col_r <= 2'd0;
            if (q_data.same_point) begin
              degen_r <= 1'b1;
              state_r <= B_EMIT;
            end else begin
              degen_r   <= 1'b0;
              nvec_r[0] <= q_data.d_x;
              nvec_r[1] <= q_data.d_y;
              nvec_r[2] <= q_data.d_z;
              nstart_r  <= 1'b1;
              state_r   <= B_NF;
            end
          end
        end
        B_NF: begin
          if (nstat.done) begin
            f_r <= nvout;
            if (!nstat.ok || (nvout[0] == '0 && nvout[1] == '0)) begin
              degen_r <= 1'b1;
              state_r <= B_EMIT;
            end else begin
              nvec_r[0] <= lavm_pkg::DIFF_W'(nvout[1]);
              nvec_r[1] <= lavm_pkg::DIFF_W'(-nvout[0]);
              nvec_r[2] <= '0;
              nstart_r  <= 1'b1;
              state_r   <= B_NR;
            end
          end
        end
        B_NR: begin
          if (nstat.done) begin
            r_r <= nvout;
            if (!nstat.ok) begin
              degen_r <= 1'b1;
              state_r <= B_EMIT;
            end else begin
              step_r  <= '0;
              for (int i = 0; i < 3; i++) begin
                acc_r[i] <= '0;
              end
              state_r <= B_CROSS;
            end
          end
        end
        B_CROSS: begin
          step_r <= step_r + 1'b1;
          if (step_r == BSTEP_W'(CROSS_N + 1)) begin
            for (int i = 0; i < 3; i++) begin
              nvec_r[i] <= lavm_pkg::DIFF_W'(acc_r[i]);
            end
            nstart_r <= 1'b1;
            state_r  <= B_NU;
          end
        end
        B_NU: begin
          if (nstat.done) begin
            u_r <= nvout;
            if (!nstat.ok) begin
              degen_r <= 1'b1;
              state_r <= B_EMIT;
            end else begin
              step_r  <= '0;
              for (int i = 0; i < 3; i++) begin
                acc_r[i] <= '0;
              end
              state_r <= B_DOT;
            end
          end
        end
        B_DOT: begin
          step_r <= step_r + 1'b1;
          if (step_r == BSTEP_W'(DOT_N + 1)) begin
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          out_valid_r <= 1'b1;
          out_word_r  <= col_word;
          col_r       <= col_r + 2'd1;
          if (col_r == lavm_pkg::LAST_COL) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  `LAVM_ASSERT_IMP(a_last_col, clk, rst_n, out_valid_r && out_word_r.last_column, out_word_r.column_index == lavm_pkg::LAST_COL)
  `LAVM_ASSERT_IMP(a_degen_zero, clk, rst_n, out_valid_r && out_word_r.degenerate, out_word_r.row0_value == '0 && out_word_r.row1_value == '0 && out_word_r.row2_value == '0 && out_word_r.row3_value == '0)
  `LAVM_ASSERT_NXT(a_gap_after_last, clk, rst_n, out_valid_r && out_word_r.last_column, !out_valid_r)

endmodule

### src/look_at_view_matrix.sv
// Top level of the fixed-point look-at view matrix block.
// Coincident points skip the normalisations, and a view along z skips all but the first;
// both give degenerate columns with every row zero.
// Throughput: one item per back-end run; the four columns leave on consecutive cycles and up
// to three items wait. Synchronous reset empties the input stage and queue and stops any item.
module look_at_view_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lavm_pkg::in_word_t  in_word,
  output logic                out_valid,
  output lavm_pkg::out_word_t out_word
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  lavm_pkg::job_t push_data;
  lavm_pkg::job_t pop_data;

  lavm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  lavm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  lavm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
